### design/block_average_pixelate_unit_defines.svh
// ---------------------------------------------------------------------------
// Block average pixelate unit: assertion macros
// Shared check forms for the top level, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_PIXELATE_UNIT_DEFINES_SVH
`define BLOCK_AVERAGE_PIXELATE_UNIT_DEFINES_SVH

// same-cycle implication
`define BAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bap_pkg.sv
// ---------------------------------------------------------------------------
// Block average pixelate package
// Field widths, register indexes and divider control types.
// ---------------------------------------------------------------------------
package bap_pkg;

    localparam int PIX_W  = 8;
    localparam int POS_W  = 11;
    localparam int IB_W   = 6;
    localparam int BS_W   = 7;
    localparam int DIM_W  = 12;
    localparam int SUM_W  = 20;
    localparam int CNT_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_NW = 20;
    localparam int DIV_DW = 13;
    localparam int DIV_CW = 5;

    localparam logic [BS_W-1:0]  BS_MAX   = 7'd64;
    localparam logic [DIM_W-1:0] DIM_MAX  = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic start;
        logic take;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/block_average_pixelate_unit.sv
// ---------------------------------------------------------------------------
// Block average pixelate unit
// Raster pixels in, truncated mean of each square block out, edges clipped.
// ---------------------------------------------------------------------------
//  channel | ports                                   | role
//  --------+-----------------------------------------+------------------------
//  s_      | s_valid s_ready s_pixel                 | one pixel per item
//  m_      | m_valid m_ready m_block_mean m_block_row| one block mean per item
//          | m_block_col m_frame_done                |
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | register writes
//
//  A pixel that closes no block is taken every cycle while no position
//  recalculation is pending; column sums go through the read, add and write
//  of the sum memory. A pixel that closes a block yields its mean through the
//  20-step serial divider, which takes one closing pixel at a time.
//  After each register write the input stalls while the block positions are
//  divided again by the block size. No clearing pass.
//  Reset is synchronous; the result register holds while m_ready is low.
// ---------------------------------------------------------------------------
`include "block_average_pixelate_unit_defines.svh"

module block_average_pixelate_unit
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_block_mean,
    output logic [POS_W-1:0]     m_block_row,
    output logic [POS_W-1:0]     m_block_col,
    output logic                 m_frame_done
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [BS_W-1:0]   block_size_reg, block_size_next;
    logic [DIM_W-1:0]  image_width_reg, image_width_next;
    logic [DIM_W-1:0]  image_height_reg, image_height_next;
    logic              recalc_reg, recalc_next;

    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [POS_W-1:0]  row_pos_reg, row_pos_next;
    logic [IB_W-1:0]   cib_reg, cib_next;
    logic [IB_W-1:0]   rib_reg, rib_next;
    logic [IB_W-1:0]   col_mod_reg, col_mod_next;
    logic [IB_W-1:0]   row_mod_reg, row_mod_next;
    logic [POS_W-1:0]  blk_col_reg, blk_col_next;
    logic [POS_W-1:0]  blk_row_reg, blk_row_next;

    logic              s2_valid_reg;
    logic              s2_emit_reg;
    logic [CNT_W-1:0]  s2_cnt_reg;
    logic [POS_W-1:0]  s2_row_reg;
    logic [POS_W-1:0]  s2_col_reg;
    logic              s2_fd_reg;

    logic [POS_W-1:0]  dm_row_reg;
    logic [POS_W-1:0]  dm_col_reg;
    logic              dm_fd_reg;

    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_mean_reg;
    logic [POS_W-1:0]  m_row_reg;
    logic [POS_W-1:0]  m_col_reg;
    logic              m_fd_reg;

    logic [BS_W-1:0]   bs_eff;
    logic [BS_W-1:0]   bs_m1;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              row_end;
    logic              row_last;
    logic              frame_end;
    logic              cib_ge;
    logic              rib_ge;
    logic              col_mod_ge;
    logic              row_mod_ge;
    logic              emit_now;
    logic              first_now;
    logic              in_acc;
    logic [ADDR_W-1:0] sum_addr;
    logic [BS_W-1:0]   cib_p1;
    logic [BS_W-1:0]   rib_p1;
    logic [2*BS_W-1:0] cnt_prod;
    logic [SUM_W-1:0]  sum;

    div_ctrl_t         mean_ctrl;
    div_stat_t         mean_stat;
    logic [DIV_NW-1:0] mean_quo;
    logic [DIV_DW-1:0] mean_rem;
    div_ctrl_t         pos_ctrl;
    div_stat_t         pcol_stat;
    div_stat_t         prow_stat;
    logic [DIV_NW-1:0] pcol_quo;
    logic [DIV_DW-1:0] pcol_rem;
    logic [DIV_NW-1:0] prow_quo;
    logic [DIV_DW-1:0] prow_rem;
    logic              pos_busy;
    logic              pos_load;

    // effective limits
    always_comb begin
        bs_eff = block_size_reg;
        if (bs_eff == '0) begin
            bs_eff = BS_W'(1);
        end
        if (bs_eff > BS_MAX) begin
            bs_eff = BS_MAX;
        end
        w_eff = image_width_reg;
        if (w_eff == '0) begin
            w_eff = DIM_W'(1);
        end
        if (w_eff > DIM_MAX) begin
            w_eff = DIM_MAX;
        end
        if (int'(w_eff) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = image_height_reg;
        if (h_eff == '0) begin
            h_eff = DIM_W'(1);
        end
        if (h_eff > DIM_MAX) begin
            h_eff = DIM_MAX;
        end
    end

    assign bs_m1      = bs_eff - 1'b1;
    assign row_end    = {1'b0, col_pos_reg} >= (w_eff - 1'b1);
    assign row_last   = {1'b0, row_pos_reg} >= (h_eff - 1'b1);
    assign frame_end  = row_end && row_last;
    assign cib_ge     = {1'b0, cib_reg} >= bs_m1;
    assign rib_ge     = {1'b0, rib_reg} >= bs_m1;
    assign col_mod_ge = {1'b0, col_mod_reg} >= bs_m1;
    assign row_mod_ge = {1'b0, row_mod_reg} >= bs_m1;
    assign emit_now   = (row_end || cib_ge) && (row_last || rib_ge);
    assign first_now  = (cib_reg == '0) && (rib_reg == '0);
    assign cib_p1     = {1'b0, cib_reg} + 1'b1;
    assign rib_p1     = {1'b0, rib_reg} + 1'b1;
    assign cnt_prod   = cib_p1 * rib_p1;
    assign sum_addr   = (int'(blk_col_reg) >= MAX_WIDTH - 1) ? ADDR_W'(MAX_WIDTH - 1)
                                                             : ADDR_W'(blk_col_reg);

    assign pos_busy = pcol_stat.busy || prow_stat.busy;
    assign pos_load = pcol_stat.done;
    assign s_ready  = !recalc_reg && !pos_busy
                   && !(emit_now && (mean_stat.busy || (s2_valid_reg && s2_emit_reg)));
    assign in_acc   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration
    always_comb begin
        block_size_next   = block_size_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        recalc_next       = recalc_reg;
        if (pos_ctrl.start) begin
            recalc_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            recalc_next = 1'b1;
            case (cfg_index)
                CFG_BLOCK_SIZE:   block_size_next   = cfg_data[BS_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    // raster counters
    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        cib_next     = cib_reg;
        rib_next     = rib_reg;
        col_mod_next = col_mod_reg;
        row_mod_next = row_mod_reg;
        blk_col_next = blk_col_reg;
        blk_row_next = blk_row_reg;
        if (in_acc) begin
            if (row_end) begin
                col_pos_next = '0;
                cib_next     = '0;
                col_mod_next = '0;
                blk_col_next = '0;
                if (frame_end) begin
                    row_pos_next = '0;
                    rib_next     = '0;
                    row_mod_next = '0;
                    blk_row_next = '0;
                end else begin
                    row_pos_next = row_pos_reg + 1'b1;
                    rib_next     = rib_ge ? '0 : rib_reg + 1'b1;
                    if (row_mod_ge) begin
                        row_mod_next = '0;
                        blk_row_next = blk_row_reg + 1'b1;
                    end else begin
                        row_mod_next = row_mod_reg + 1'b1;
                    end
                end
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
                cib_next     = cib_ge ? '0 : cib_reg + 1'b1;
                if (col_mod_ge) begin
                    col_mod_next = '0;
                    blk_col_next = blk_col_reg + 1'b1;
                end else begin
                    col_mod_next = col_mod_reg + 1'b1;
                end
            end
        end else if (pos_load) begin
            col_mod_next = pcol_rem[IB_W-1:0];
            blk_col_next = pcol_quo[POS_W-1:0];
            row_mod_next = prow_rem[IB_W-1:0];
            blk_row_next = prow_quo[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg   <= BS_W'(8);
            image_width_reg  <= DIM_W'(640);
            image_height_reg <= DIM_W'(480);
            recalc_reg       <= 1'b0;
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            cib_reg          <= '0;
            rib_reg          <= '0;
            col_mod_reg      <= '0;
            row_mod_reg      <= '0;
            blk_col_reg      <= '0;
            blk_row_reg      <= '0;
            s2_valid_reg     <= 1'b0;
            s2_emit_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            block_size_reg   <= block_size_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            recalc_reg       <= recalc_next;
            col_pos_reg      <= col_pos_next;
            row_pos_reg      <= row_pos_next;
            cib_reg          <= cib_next;
            rib_reg          <= rib_next;
            col_mod_reg      <= col_mod_next;
            row_mod_reg      <= row_mod_next;
            blk_col_reg      <= blk_col_next;
            blk_row_reg      <= blk_row_next;
            s2_valid_reg     <= in_acc;
            s2_emit_reg      <= in_acc && emit_now;
            if (mean_stat.done && mean_ctrl.take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s2_cnt_reg <= cnt_prod[CNT_W-1:0];
        s2_row_reg <= blk_row_reg;
        s2_col_reg <= blk_col_reg;
        s2_fd_reg  <= frame_end;
        if (mean_ctrl.start) begin
            dm_row_reg <= s2_row_reg;
            dm_col_reg <= s2_col_reg;
            dm_fd_reg  <= s2_fd_reg;
        end
        if (mean_stat.done && mean_ctrl.take) begin
            m_mean_reg <= (mean_quo > DIV_NW'(255)) ? PIX_W'(255) : mean_quo[PIX_W-1:0];
            m_row_reg  <= dm_row_reg;
            m_col_reg  <= dm_col_reg;
            m_fd_reg   <= dm_fd_reg;
        end
    end

    bap_colsum #(
        .DEPTH (MAX_WIDTH)
    ) u_colsum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_acc),
        .in_addr  (sum_addr),
        .in_pixel (s_pixel),
        .in_first (first_now),
        .out_sum  (sum)
    );

    assign mean_ctrl.start = s2_valid_reg && s2_emit_reg;
    assign mean_ctrl.take  = !m_valid_reg || m_ready;

    bap_serdiv u_mean_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mean_ctrl),
        .dividend  (sum),
        .divisor   (s2_cnt_reg),
        .stat      (mean_stat),
        .quotient  (mean_quo),
        .remainder (mean_rem)
    );

    assign pos_ctrl.start = recalc_reg && !pos_busy;
    assign pos_ctrl.take  = 1'b1;

    bap_serdiv u_pcol_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pos_ctrl),
        .dividend  (DIV_NW'(col_pos_reg)),
        .divisor   (DIV_DW'(bs_eff)),
        .stat      (pcol_stat),
        .quotient  (pcol_quo),
        .remainder (pcol_rem)
    );

    bap_serdiv u_prow_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pos_ctrl),
        .dividend  (DIV_NW'(row_pos_reg)),
        .divisor   (DIV_DW'(bs_eff)),
        .stat      (prow_stat),
        .quotient  (prow_quo),
        .remainder (prow_rem)
    );

    assign m_valid      = m_valid_reg;
    assign m_block_mean = m_mean_reg;
    assign m_block_row  = m_row_reg;
    assign m_block_col  = m_col_reg;
    assign m_frame_done = m_fd_reg;

    `BAP_ASSERT_SAME(a_mean_start_idle, mean_ctrl.start, !mean_stat.busy, "mean divider restarted while busy")
    `BAP_ASSERT_NEXT(a_emit_to_div, s_valid && s_ready && emit_now, mean_ctrl.start, "closing item did not reach the divider")
    `BAP_ASSERT_NEXT(a_result_loaded, mean_stat.done && mean_ctrl.take, m_valid, "finished mean not presented")

endmodule

### design/bap_serdiv.sv
// ---------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle; result held until taken.
// ---------------------------------------------------------------------------
module bap_serdiv
    import bap_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctrl_t         ctrl,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output div_stat_t         stat,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic              running;
    logic              finished;

    assign finished = busy_reg && (cnt_reg == DIV_CW'(DIV_NW));
    assign running  = busy_reg && !finished;
    assign shifted  = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff     = shifted - {1'b0, den_reg};
    assign ge       = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (running) begin
            cnt_next = cnt_reg + 1'b1;
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            rem_next = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        end else if (finished && ctrl.take) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = finished;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/bap_colsum.sv
// ---------------------------------------------------------------------------
// Column sum store
// Per-block-column running sums: read on accept, add and write back next cycle.
// ---------------------------------------------------------------------------
module bap_colsum
    import bap_pkg::*;
#(
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [ADDR_W-1:0]    in_addr,
    input  logic [PIX_W-1:0]     in_pixel,
    input  logic                 in_first,
    output logic [SUM_W-1:0]     out_sum
);

    logic [SUM_W-1:0]  mem [DEPTH];
    logic [SUM_W-1:0]  rd_data_reg;
    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [PIX_W-1:0]  s2_pixel_reg;
    logic              s2_first_reg;
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [SUM_W-1:0]  old_sum;
    logic [SUM_W-1:0]  sum;

    assign old_sum = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                      : rd_data_reg;
    assign sum     = s2_first_reg ? SUM_W'(s2_pixel_reg)
                                  : old_sum + SUM_W'(s2_pixel_reg);

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            mem[s2_addr_reg] <= sum;
        end
        rd_data_reg <= mem[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= in_valid;
            fwd_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_addr_reg  <= in_addr;
        s2_pixel_reg <= in_pixel;
        s2_first_reg <= in_first;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= sum;
    end

    assign out_sum = sum;

endmodule

### dv/tb_block_average_pixelate_unit.sv
// ---------------------------------------------------------------------------
// Block average pixelate unit testbench
// Streams raster pixels through the unit under several block and image
// settings, out-of-range settings and one mid-frame change among them. Every
// accepted pixel goes through a local model of the column sums and counters;
// each block mean that comes out is checked field by field against the oldest
// one the model expects. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_block_average_pixelate_unit;
    import bap_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 500;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } block_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [PIX_W-1:0]     m_block_mean;
    logic [POS_W-1:0]     m_block_row;
    logic [POS_W-1:0]     m_block_col;
    logic                 m_frame_done;

    logic [PIX_W-1:0] pixel_q[$];
    block_result_t    block_means_q[$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    bit stall_rx   = 1'b0;
    int fail_cnt   = 0;
    int pixels_in  = 0;
    int blocks_seen = 0;
    int reg_writes = 0;

    // model of the unit
    bit [SUM_W-1:0] strip_sum [2048];
    bit [POS_W-1:0] cur_row, cur_col;
    bit [IB_W-1:0]  row_ofs, col_ofs;
    bit [BS_W-1:0]  set_bs     = 7'd8;
    bit [DIM_W-1:0] set_width  = 12'd640;
    bit [DIM_W-1:0] set_height = 12'd480;

    block_average_pixelate_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_block_mean (m_block_mean),
        .m_block_row  (m_block_row),
        .m_block_col  (m_block_col),
        .m_frame_done (m_frame_done)
    );

    always #5 aclk = ~aclk;

    function automatic void accumulate_pixel(input logic [PIX_W-1:0] px);
        int unsigned bs, w, h, idx, cnt, mean;
        bit row_end, frame_end, col_close, row_close;
        block_result_t res;
        bs = 32'(set_bs);
        if (bs < 1) bs = 1;
        if (bs > 32'(BS_MAX)) bs = 32'(BS_MAX);
        w = 32'(set_width);
        if (w < 1) w = 1;
        if (w > 32'(DIM_MAX)) w = 32'(DIM_MAX);
        h = 32'(set_height);
        if (h < 1) h = 1;
        if (h > 32'(DIM_MAX)) h = 32'(DIM_MAX);
        idx = cur_col / bs;
        if (row_ofs == 0 && col_ofs == 0) strip_sum[idx] = SUM_W'(px);
        else strip_sum[idx] = strip_sum[idx] + SUM_W'(px);

        row_end   = cur_col >= w - 1;
        frame_end = row_end && cur_row >= h - 1;
        col_close = row_end || col_ofs >= bs - 1;
        row_close = cur_row >= h - 1 || row_ofs >= bs - 1;
        if (col_close && row_close) begin
            cnt  = (col_ofs + 1) * (row_ofs + 1);
            mean = strip_sum[idx] / cnt;
            if (mean > 255) mean = 255;
            res.mean = PIX_W'(mean);
            res.row  = POS_W'(cur_row / bs);
            res.col  = POS_W'(cur_col / bs);
            res.done = frame_end;
            block_means_q = {block_means_q, res};
        end

        if (row_end) begin
            cur_col = '0;
            col_ofs = '0;
            if (frame_end) begin
                cur_row = '0;
                row_ofs = '0;
            end else begin
                cur_row = cur_row + 1'b1;
                row_ofs = (row_ofs >= bs - 1) ? '0 : row_ofs + 1'b1;
            end
        end else begin
            cur_col = cur_col + 1'b1;
            col_ofs = (col_ofs >= bs - 1) ? '0 : col_ofs + 1'b1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] any_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accumulate_pixel(s_pixel);
                pixels_in++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        block_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_block_mean, m_block_row, m_block_col, m_frame_done};
            blocks_seen++;
            if (block_means_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected block: mean=%0d row=%0d col=%0d done=%0b",
                             got.mean, got.row, got.col, got.done);
            end else begin
                want = block_means_q.pop_front();
                if (got.mean !== want.mean || got.row !== want.row ||
                    got.col !== want.col || got.done !== want.done) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("block mismatch: expected mean=%0d row=%0d col=%0d done=%0b, got mean=%0d row=%0d col=%0d done=%0b",
                                 want.mean, want.row, want.col, want.done,
                                 got.mean, got.row, got.col, got.done);
                end
            end
        end
        m_ready <= !stall_rx && ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_BLOCK_SIZE:   set_bs     = data[BS_W-1:0];
            CFG_IMAGE_WIDTH:  set_width  = data;
            CFG_IMAGE_HEIGHT: set_height = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int bs, input int w, input int h);
        write_reg(CFG_BLOCK_SIZE, DIM_W'(bs));
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
    endtask

    task automatic feed(input int n, input int fill, input int mode);
        @(negedge aclk);
        case (mode)
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            3: begin idle_pct = 36; stall_pct = 36; end
            default: begin idle_pct = 0; stall_pct = 0; end
        endcase
        repeat (n) pixel_q = {pixel_q, (fill < 0) ? any_pixel() : PIX_W'(fill)};
    endtask

    task automatic settle();
        @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || block_means_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        int phase, rand_items, bs, w, h, frames;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero block size acts as one: every pixel closes a block
        configure(0, 4, 1);
        feed(1, 0, 0);
        feed(1, 255, 0);
        feed(2, -1, 0);
        settle();

        // three rows into a 4x4 block row, then shrink block and height
        configure(4, 4, 9);
        feed(12, 255, 0);
        settle();
        write_reg(CFG_BLOCK_SIZE, DIM_W'(1));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(2));
        feed(4, 255, 0);
        settle();

        // oversized block, zero width and height, unused register index
        configure(127, 0, 0);
        write_reg(CFG_SPARE, 12'hFFF);
        feed(1, 255, 0);
        settle();

        // clipped edge blocks
        configure(2, 3, 2);
        feed(6, -1, 0);
        settle();

        // largest block, clipped along a wide row and a tall column
        configure(64, 130, 1);
        feed(130, -1, 0);
        settle();
        configure(64, 1, 130);
        feed(130, -1, 0);
        settle();

        phase = 0;
        rand_items = 0;
        while (rand_items < 900 || phase <= 5) begin
            if (phase == 5) begin
                // hold off the receiver until the unit backs up
                configure(1, 16, 8);
                feed(128, -1, 0);
                stall_rx = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stall_rx = 1'b0;
                rand_items += 128;
            end else begin
                case ($urandom_range(19))
                    0: bs = 0;
                    1: bs = 64;
                    2: bs = $urandom_range(65, 4095);
                    3: bs = $urandom_range(9, 63);
                    default: bs = $urandom_range(1, 8);
                endcase
                w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
                h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                frames = $urandom_range(1, 2);
                configure(bs, w, h);
                feed((w == 0 ? 1 : w) * (h == 0 ? 1 : h) * frames, -1, phase % 4);
                rand_items += (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * frames;
            end
            settle();
            phase++;
        end

        $display("run: %0d pixels in, %0d block means checked, %0d register writes",
                 pixels_in, blocks_seen, reg_writes);
        $display("run: %0d setting phases, %0d mismatches", phase + 7, fail_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### block_average_pixelate_unit.f
+incdir+design
design/bap_pkg.sv
design/bap_serdiv.sv
design/bap_colsum.sv
design/block_average_pixelate_unit.sv
dv/tb_block_average_pixelate_unit.sv
